@@ sv/itb_pkg.sv @@
// shared constants, types and the digit-to-character map for integer_to_base_digits
`timescale 1ns / 1ps

package itb_pkg;

   // default width of the signed input value
   localparam int VALUE_BITS_DEF = 32;

   // radix field width and the legal radix span
   localparam int RADIX_BITS = 6;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

   // ascii codes
   localparam int CHAR_BITS = 8;
   localparam logic [CHAR_BITS-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_ALPHA = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = 6'd10;

   // status of the serial divider, seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic quot_nz;
   } div_status_type;

   // digit value to its ascii character
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ch;
      if (d < DECIMAL_DIGITS) begin
         ch = CH_ZERO + {2'b00, d};
      end else begin
         ch = CH_ALPHA + {2'b00, d - DECIMAL_DIGITS};
      end
      return ch;
   endfunction

endpackage

@@ sv/itb_div.sv @@
// bit-serial restoring divider: one quotient bit per cycle, small remainder
`timescale 1ns / 1ps

module itb_div #(
   parameter int VALUE_BITS = itb_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VALUE_BITS-1:0]           dividend,
   input  logic [itb_pkg::RADIX_BITS-1:0]  divisor,
   output logic [VALUE_BITS-1:0]           quotient,
   output logic [itb_pkg::RADIX_BITS-1:0]  remainder,
   output itb_pkg::div_status_type         status
);

   localparam int STEP_W = $clog2(VALUE_BITS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

   logic [VALUE_BITS-1:0]          quo_ff, quo_in;
   logic [itb_pkg::RADIX_BITS-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           nz_ff, nz_in;
   logic [itb_pkg::RADIX_BITS:0]   trial;
   logic [itb_pkg::RADIX_BITS:0]   diff;
   logic                           fits;

   // one shift-subtract step: dividend bits leave at the top, quotient bits enter below
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   // step control
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in   = nz_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         nz_in   = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[itb_pkg::RADIX_BITS-1:0] : trial[itb_pkg::RADIX_BITS-1:0];
         nz_in   = nz_ff | fits;
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      nz_ff  <= nz_in;
   end

   assign quotient       = quo_ff;
   assign remainder      = rem_ff;
   assign status.busy    = busy_ff;
   assign status.done    = done_ff;
   assign status.quot_nz = nz_ff;

endmodule

@@ sv/integer_to_base_digits.sv @@
// top level: signed integer to ascii text in radix 2..36, most significant character first
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready  tdata = value, radix
//   rsp       out   rsp_tvalid/rsp_tready  tdata = text_char, tlast = final_char
//
// each digit takes one pass of the bit-serial divider, one quotient bit per cycle;
// each character then takes a digit store read and then an output load.
// reset is synchronous and clears the sequencer, the divider control and the output valid.
// a stalled rsp holds the output register and the sequencer waits; req is taken again
// once the last character is in the output register, even while it waits to be taken.
`timescale 1ns / 1ps

module integer_to_base_digits #(
   parameter int VALUE_BITS = itb_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [((VALUE_BITS + itb_pkg::RADIX_BITS + 7) / 8) * 8 - 1:0] req_tdata, // value, radix
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // text_char
   output logic                   rsp_tlast    // final_char
);

   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int IDX_W  = $clog2(VALUE_BITS);
   localparam int RB     = itb_pkg::RADIX_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    neg_ff, neg_in;
   logic [RB-1:0]           base_ff, base_in;
   logic [RB-1:0]           rd_ff;
   logic [RB-1:0]           digit_mem [VALUE_BITS];
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;

   logic                    accept;
   logic                    out_free;
   logic [VALUE_BITS-1:0]   in_value;
   logic [RB-1:0]           in_radix;
   logic [VALUE_BITS-1:0]   in_mag;
   logic                    div_start;
   logic [VALUE_BITS-1:0]   div_dividend;
   logic [VALUE_BITS-1:0]   div_quot;
   logic [RB-1:0]           div_rem;
   itb_pkg::div_status_type div_status;
   logic                    mem_wr;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;
   logic [CNT_W-1:0]        count_dec;

   // input beat unpacking, magnitude and radix clamp
   always_comb begin
      in_value = req_tdata[VALUE_BITS-1:0];
      in_radix = req_tdata[VALUE_BITS+RB-1:VALUE_BITS];
      in_mag   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
      if (in_radix < itb_pkg::RADIX_MIN) begin
         base_in = itb_pkg::RADIX_MIN;
      end else if (in_radix > itb_pkg::RADIX_MAX) begin
         base_in = itb_pkg::RADIX_MAX;
      end else begin
         base_in = in_radix;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign count_dec  = count_ff - 1'b1;
   assign wr_idx     = count_ff[IDX_W-1:0];
   assign rd_idx     = count_dec[IDX_W-1:0];
   assign mem_wr     = (state_ff == ST_DIV) && div_status.done;

   // divider feed: the new magnitude, then each quotient in turn
   assign div_start    = accept || (mem_wr && div_status.quot_nz);
   assign div_dividend = accept ? in_mag : div_quot;

   itb_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (base_ff),
      .quotient (div_quot),
      .remainder(div_rem),
      .status   (div_status)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = in_value[VALUE_BITS-1];
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = count_ff + 1'b1;
               if (!div_status.quot_nz) begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itb_pkg::CH_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itb_pkg::digit_char(rd_ff);
               out_last_in  = (count_ff == CNT_W'(1));
               count_in     = count_dec;
               state_in     = (count_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // base is loaded only with a new item
   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= base_in;
      end
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         digit_mem[wr_idx] <= div_rem;
      end
      rd_ff <= digit_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   // the divider is never running while a new item may enter
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy && !div_status.done)
      else $error("divider active while idle");

   // the digit count never passes the value width
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count overflow");

   // loading the last character returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && count_ff == CNT_W'(1))
      |=> (state_ff == ST_IDLE) && out_valid_ff && out_last_ff)
      else $error("last character did not end the item");

   // a stalled output beat is not overwritten
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff && $stable(out_char_ff))
      else $error("stalled character changed");

endmodule
